@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/cmdh_pkg.sv @@
package cmdh_pkg;

   localparam int FaceBinsDefault = 9;
   localparam int ComponentBitsDefault = 16;
   localparam int CountBitsDefault = 16;

   localparam int VecW = 16;
   localparam int IndexW = 9;
   localparam int FaceW = 3;
   localparam int BinW = 4;
   localparam int CountW = 16;

   localparam logic CMD_BIN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [FaceW-1:0] FACE_PX = 3'd0;
   localparam logic [FaceW-1:0] FACE_NX = 3'd1;
   localparam logic [FaceW-1:0] FACE_PY = 3'd2;
   localparam logic [FaceW-1:0] FACE_NY = 3'd3;
   localparam logic [FaceW-1:0] FACE_PZ = 3'd4;
   localparam logic [FaceW-1:0] FACE_NZ = 3'd5;

   // back-end sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_WRITE = 5'b10000
   } back_state_type;

endpackage

@@ rtl/core/cube_map_direction_histogram_unit.sv @@
// channel | ports                                              | direction
// req     | req_valid/ready, cmd, vec_x/y/z, bin_index         | in
// rsp     | rsp_valid/ready, face_valid, face, bin_col/row/count | out
// a read or zero-vector item passes the read and write states in the back end; a
// binned vector first passes the one-bit-per-cycle divider, then the
// read-modify-write of the counter memory.
// after reset a clearing pass zeroes every entry of the store.
// the front queue holds two items, so input is taken while the back end works until the queue is full.
module cube_map_direction_histogram_unit import cmdh_pkg::*; #(
   parameter int FaceBins = FaceBinsDefault,
   parameter int ComponentBits = ComponentBitsDefault,
   parameter int CountBits = CountBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic signed [VecW-1:0] req_vec_x,
   input  logic signed [VecW-1:0] req_vec_y,
   input  logic signed [VecW-1:0] req_vec_z,
   input  logic [IndexW-1:0]      req_bin_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_face_valid,
   output logic [FaceW-1:0]       rsp_face,
   output logic [BinW-1:0]        rsp_bin_col,
   output logic [BinW-1:0]        rsp_bin_row,
   output logic [CountW-1:0]      rsp_bin_count
);

   localparam int AddrW = $clog2(6 * FaceBins * FaceBins);

   logic q_valid, q_ready, q_read, q_face_valid, q_in_range;
   logic [FaceW-1:0] q_face;
   logic [ComponentBits:0] q_major;
   logic [ComponentBits+1:0] q_unum, q_vnum;
   logic [AddrW-1:0] q_addr;

   // classify and queue
   cmdh_front #(.ComponentBits(ComponentBits), .FaceBins(FaceBins), .AddrW(AddrW)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_vec_x, .req_vec_y,
      .req_vec_z, .req_bin_index, .q_valid, .q_ready, .q_read, .q_face_valid,
      .q_face, .q_major, .q_unum, .q_vnum, .q_in_range, .q_addr
   );

   // divide, update counters, respond
   cmdh_back #(.ComponentBits(ComponentBits), .FaceBins(FaceBins),
               .CountBits(CountBits), .AddrW(AddrW)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_read, .q_face_valid, .q_face,
      .q_major, .q_unum, .q_vnum, .q_in_range, .q_addr, .rsp_valid, .rsp_ready,
      .rsp_face_valid, .rsp_face, .rsp_bin_col, .rsp_bin_row, .rsp_bin_count
   );

endmodule

@@ rtl/core/cmdh_ram.sv @@
module cmdh_ram #(
   parameter int Width = 16,
   parameter int Depth = 486
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/cmdh_front.sv @@
module cmdh_front import cmdh_pkg::*; #(
   parameter int ComponentBits = ComponentBitsDefault,
   parameter int FaceBins = FaceBinsDefault,
   parameter int AddrW = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic signed [VecW-1:0]     req_vec_x,
   input  logic signed [VecW-1:0]     req_vec_y,
   input  logic signed [VecW-1:0]     req_vec_z,
   input  logic [IndexW-1:0]          req_bin_index,
   output logic                       q_valid,
   input  logic                       q_ready,
   output logic                       q_read,
   output logic                       q_face_valid,
   output logic [FaceW-1:0]           q_face,
   output logic [ComponentBits:0]     q_major,
   output logic [ComponentBits+1:0]   q_unum,
   output logic [ComponentBits+1:0]   q_vnum,
   output logic                       q_in_range,
   output logic [AddrW-1:0]           q_addr
);

   localparam int CB = ComponentBits;
   localparam int Depth = 6 * FaceBins * FaceBins;
   localparam int QDepth = 2;
   localparam int EntryW = 1 + 1 + FaceW + (CB + 1) + 2 * (CB + 2) + 1 + AddrW;

   logic signed [CB:0] x, y, z, ax, ay, az;
   logic signed [CB+1:0] major_s, u_s, v_s;
   logic fv;
   logic [FaceW-1:0] fc;
   logic [EntryW-1:0] entry;
   logic [EntryW-1:0] q_mem_ff [QDepth];
   logic q_wp_ff, q_rp_ff;
   logic [1:0] q_cnt_ff;
   logic push, pop;

   // sign-extend the used component bits
   assign x = (CB+1)'(signed'(req_vec_x[CB-1:0]));
   assign y = (CB+1)'(signed'(req_vec_y[CB-1:0]));
   assign z = (CB+1)'(signed'(req_vec_z[CB-1:0]));
   assign ax = x[CB] ? -x : x;
   assign ay = y[CB] ? -y : y;
   assign az = z[CB] ? -z : z;

   // face selection, first matching rule wins
   always_comb begin
      fv = 1'b1;
      fc = FACE_PX;
      major_s = '0;
      u_s = '0;
      v_s = '0;
      if (x >= ay && x > az) begin
         fc = FACE_PX; major_s = x; u_s = -z; v_s = -y;
      end else if (x < -ay && x <= -az) begin
         fc = FACE_NX; major_s = -x; u_s = z; v_s = -y;
      end else if (y >= az && y > ax) begin
         fc = FACE_PY; major_s = y; u_s = x; v_s = z;
      end else if (y < -az && y <= -ax) begin
         fc = FACE_NY; major_s = -y; u_s = x; v_s = -z;
      end else if (z >= ax && z > ay) begin
         fc = FACE_PZ; major_s = z; u_s = x; v_s = -y;
      end else if (z < -ax && z <= -ay) begin
         fc = FACE_NZ; major_s = -z; u_s = -x; v_s = -y;
      end else begin
         fv = 1'b0;
      end
   end

   // queue entry: numerators are minor + major, always in [0, 2*major]
   always_comb begin
      logic [CB+1:0] un, vn;
      un = u_s + major_s;
      vn = v_s + major_s;
      entry = {req_cmd, fv & (req_cmd == CMD_BIN), fc, major_s[CB:0], un, vn,
               (32'(req_bin_index) < Depth),
               AddrW'(req_bin_index)};
   end

   assign req_ready = (q_cnt_ff != 2'(QDepth));
   assign push = req_valid && req_ready;
   assign q_valid = (q_cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign {q_read, q_face_valid, q_face, q_major, q_unum, q_vnum, q_in_range, q_addr}
      = q_mem_ff[q_rp_ff];

   // two-entry queue between front and back
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff <= 1'b0;
         q_rp_ff <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         if (push) q_wp_ff <= ~q_wp_ff;
         if (pop) q_rp_ff <= ~q_rp_ff;
         q_cnt_ff <= q_cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) q_mem_ff[q_wp_ff] <= entry;
   end

endmodule

@@ rtl/core/cmdh_back.sv @@
module cmdh_back import cmdh_pkg::*; #(
   parameter int ComponentBits = ComponentBitsDefault,
   parameter int FaceBins = FaceBinsDefault,
   parameter int CountBits = CountBitsDefault,
   parameter int AddrW = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     q_ready,
   input  logic                     q_read,
   input  logic                     q_face_valid,
   input  logic [FaceW-1:0]         q_face,
   input  logic [ComponentBits:0]   q_major,
   input  logic [ComponentBits+1:0] q_unum,
   input  logic [ComponentBits+1:0] q_vnum,
   input  logic                     q_in_range,
   input  logic [AddrW-1:0]         q_addr,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_face_valid,
   output logic [FaceW-1:0]         rsp_face,
   output logic [BinW-1:0]          rsp_bin_col,
   output logic [BinW-1:0]          rsp_bin_row,
   output logic [CountW-1:0]        rsp_bin_count
);

   localparam int CB = ComponentBits;
   localparam int Depth = 6 * FaceBins * FaceBins;
   localparam int SW = $clog2(FaceBins + 1);
   // quotient bits of num*S / (2*major); num <= 2*major so quotient <= S
   localparam int QW = SW;
   localparam int NW = CB + 2 + SW;
   localparam int DW = CB + 2;
   localparam int StepW = $clog2(QW + 1);
   localparam logic [CountBits-1:0] CountMax = '1;

   back_state_type st_ff, st_in;
   logic [AddrW-1:0] clr_ff;
   logic [NW-1:0] ur_ff, vr_ff;
   logic [QW-1:0] uq_ff, vq_ff;
   logic [DW-1:0] den_ff;
   logic [StepW-1:0] step_ff;
   logic rd_mode_ff, fv_ff, inr_ff;
   logic [FaceW-1:0] face_ff;
   logic [AddrW-1:0] addr_ff;
   logic [BinW-1:0] col_ff, row_ff;
   logic out_v_ff;
   logic [CountW-1:0] out_cnt_ff;
   logic out_fv_ff;
   logic [FaceW-1:0] out_face_ff;
   logic [BinW-1:0] out_col_ff, out_row_ff;

   logic wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr, bin_addr;
   logic [CountBits-1:0] wr_data, rd_data, inc;
   logic [QW-1:0] cq, rq;
   logic [NW-1:0] dshift;

   cmdh_ram #(.Width(CountBits), .Depth(Depth)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign q_ready = (st_ff == ST_IDLE) && !out_v_ff;
   assign dshift = NW'(den_ff) << (QW - 1 - 32'(step_ff));
   assign cq = (uq_ff > QW'(FaceBins - 1)) ? QW'(FaceBins - 1) : uq_ff;
   assign rq = (vq_ff > QW'(FaceBins - 1)) ? QW'(FaceBins - 1) : vq_ff;
   assign inc = (rd_data == CountMax) ? rd_data : rd_data + 1'b1;
   // bin address from face, row and column once quotients are known
   assign bin_addr = AddrW'(32'(face_ff) * FaceBins * FaceBins
                            + 32'(rq) * FaceBins + 32'(cq));
   assign rd_addr = (st_ff == ST_READ && fv_ff) ? bin_addr : addr_ff;

   // memory write: clearing pass, read-clear, or increment
   always_comb begin
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      unique case (st_ff)
         ST_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff;
         end
         ST_WRITE: begin
            wr_en = fv_ff || (rd_mode_ff && inr_ff);
            wr_data = rd_mode_ff ? '0 : inc;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLEAR: if (32'(clr_ff) == Depth - 1) st_in = ST_IDLE;
         ST_IDLE: if (q_valid && q_ready) st_in = q_face_valid ? ST_DIV : ST_READ;
         ST_DIV: if (32'(step_ff) == QW - 1) st_in = ST_READ;
         ST_READ: st_in = ST_WRITE;
         ST_WRITE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rsp_valid && rsp_ready) out_v_ff <= 1'b0;
         if (st_ff == ST_WRITE) out_v_ff <= 1'b1;
      end
      // take an item from the queue
      if (st_ff == ST_IDLE && q_valid && q_ready) begin
         rd_mode_ff <= q_read;
         fv_ff <= q_face_valid;
         face_ff <= q_face;
         inr_ff <= q_in_range;
         addr_ff <= q_addr;
         ur_ff <= NW'(q_unum) * NW'(FaceBins);
         vr_ff <= NW'(q_vnum) * NW'(FaceBins);
         den_ff <= DW'({q_major, 1'b0});
         uq_ff <= '0;
         vq_ff <= '0;
         step_ff <= '0;
      end
      // restoring division, one quotient bit per cycle for both axes
      if (st_ff == ST_DIV) begin
         step_ff <= step_ff + 1'b1;
         if (ur_ff >= dshift) begin
            ur_ff <= ur_ff - dshift;
            uq_ff <= {uq_ff[QW-2:0], 1'b1};
         end else begin
            uq_ff <= {uq_ff[QW-2:0], 1'b0};
         end
         if (vr_ff >= dshift) begin
            vr_ff <= vr_ff - dshift;
            vq_ff <= {vq_ff[QW-2:0], 1'b1};
         end else begin
            vq_ff <= {vq_ff[QW-2:0], 1'b0};
         end
      end
      // keep bins and bin address for the write
      if (st_ff == ST_READ && fv_ff) begin
         col_ff <= BinW'(cq);
         row_ff <= BinW'(rq);
         addr_ff <= bin_addr;
      end
      // result register
      if (st_ff == ST_WRITE) begin
         out_fv_ff <= fv_ff;
         out_face_ff <= fv_ff ? face_ff : '0;
         out_col_ff <= fv_ff ? col_ff : '0;
         out_row_ff <= fv_ff ? row_ff : '0;
         if (fv_ff) out_cnt_ff <= CountW'(inc);
         else if (rd_mode_ff && inr_ff) out_cnt_ff <= CountW'(rd_data);
         else out_cnt_ff <= '0;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_face_valid = out_fv_ff;
   assign rsp_face = out_face_ff;
   assign rsp_bin_col = out_col_ff;
   assign rsp_bin_row = out_row_ff;
   assign rsp_bin_count = out_cnt_ff;

endmodule

@@ rtl/core/cmdh_checker.sv @@
`include "assert_macros.svh"
module cmdh_checker import cmdh_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_face_valid,
   input logic [FaceW-1:0]   rsp_face,
   input logic [BinW-1:0]    rsp_bin_col,
   input logic [BinW-1:0]    rsp_bin_row,
   input logic [CountW-1:0]  rsp_bin_count
);

   `ASSERT_IMPL(a_face_range, clock, reset, rsp_valid && rsp_face_valid, rsp_face <= FACE_NZ)
   `ASSERT_IMPL(a_nofv_zero, clock, reset, rsp_valid && !rsp_face_valid,
                rsp_face == '0 && rsp_bin_col == '0 && rsp_bin_row == '0)
   `ASSERT_IMPL(a_count_nz, clock, reset, rsp_valid && rsp_face_valid, rsp_bin_count != '0)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_bin_count))

endmodule

bind cube_map_direction_histogram_unit cmdh_checker u_cmdh_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_face_valid, .rsp_face,
   .rsp_bin_col, .rsp_bin_row, .rsp_bin_count
);
